// File: src/poc_pkg.sv
// Package for the priority ordered cache: widths, beat structs, FSM states.
// No dependencies.
`default_nettype none
package poc_pkg;
  localparam int DEPTH     = 16;
  localparam int KEY_BITS  = 32;
  localparam int PRIO_BITS = 16;
  localparam int DATA_BITS = 32;
  localparam int IDX_BITS  = $clog2(DEPTH);
  localparam int CNT_BITS  = $clog2(DEPTH + 1);
  localparam int ENT_BITS  = KEY_BITS + PRIO_BITS + DATA_BITS;
  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  typedef struct packed {
    logic                 mode;
    logic [KEY_BITS-1:0]  key;
    logic [PRIO_BITS-1:0] priority_req;
    logic [DATA_BITS-1:0] payload;
  } req_t;

  typedef struct packed {
    logic                 hit;
    logic [DATA_BITS-1:0] hit_payload;
    logic [PRIO_BITS-1:0] hit_priority;
    logic                 evicted;
    logic [KEY_BITS-1:0]  evicted_key;
    logic [DATA_BITS-1:0] evicted_payload;
    logic [PRIO_BITS-1:0] evicted_priority;
    logic [31:0]          hits_so_far;
    logic [31:0]          misses_so_far;
    logic [CNT_BITS-1:0]  entries_held;
  } rsp_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]  key;
    logic [PRIO_BITS-1:0] prio;
    logic [DATA_BITS-1:0] data;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_EVICT, ST_SHIFT, ST_PLACE, ST_DONE
  } state_t;
endpackage
`default_nettype wire

// File: src/poc_ram.sv
// Generic single port RAM with registered read.
// No dependencies.
`default_nettype none
module poc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// File: src/priority_ordered_cache_top.sv
// Priority ordered cache: entries held in one RAM, sorted highest priority first.
// Depends on poc_pkg and poc_ram.
// A lookup reads the entries in order from slot 0 and ends at the first key match or
// after the last entry. An insert scans for the first entry whose priority is not above
// its own, moves it and all later entries up one slot, top down, and writes the new one
// there, or appends it at the end. When full, an insert first evicts the last entry.
// One item at a time; busy is high until the result cycle, when the next beat may start.
// Reset clears the counters and entry count and sets capacity to 16; RAM is not cleared.
// Results are a one cycle strobe; the receiver cannot stall.
`default_nettype none
module priority_ordered_cache_top
  import poc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire req_t                req,
  input  wire logic                cfg_we,
  input  wire logic [4:0]          cfg_data,
  output logic                     done,
  output rsp_t                     rsp
);
  state_t state, state_next;
  req_t cur;
  logic [4:0] capacity;
  logic [CNT_BITS-1:0] count;
  logic [31:0] hits, misses;
  // idx: address under scan/shift; rd_pend: read data from idx-last is valid
  logic [CNT_BITS-1:0] idx, pos;
  logic rd_pend;
  logic we;
  logic [IDX_BITS-1:0] addr;
  entry_t wdata, rdata;
  logic [CNT_BITS-1:0] eff_cap;
  logic full;

  poc_ram #(.WIDTH(ENT_BITS), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  always_comb begin
    if (capacity == 5'd0 || 32'(capacity) > DEPTH) eff_cap = CNT_BITS'(DEPTH);
    else eff_cap = CNT_BITS'(capacity);
  end
  assign full = (count != '0) && (count >= eff_cap);
  assign busy = (state != ST_IDLE);

  // Next state. SCAN issues reads at idx and checks the entry from the last read.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start) state_next = (req.mode == MODE_INSERT && full) ? ST_EVICT : ST_SCAN;
      ST_EVICT: state_next = rd_pend ? ST_SCAN : ST_EVICT;
      ST_SCAN: begin
        if (rd_pend) begin
          if (cur.mode == MODE_LOOKUP) begin
            if (rdata.key == cur.key) state_next = ST_DONE;
            else if (idx == count) state_next = ST_DONE;
          end else if (!(rdata.prio > cur.priority_req)) begin
            state_next = ST_SHIFT;
          end else if (idx == count) begin
            state_next = ST_PLACE;
          end
        end else if (idx == count) begin
          state_next = (cur.mode == MODE_LOOKUP) ? ST_DONE : ST_PLACE;
        end
      end
      ST_SHIFT: if (idx == pos && !rd_pend) state_next = ST_PLACE;
      ST_PLACE: state_next = ST_DONE;
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // RAM port: shift runs from the top down, read idx-1 then write it to idx.
  always_comb begin
    we = 1'b0;
    addr = idx[IDX_BITS-1:0];
    wdata = rdata;
    unique case (state)
      ST_SHIFT: begin
        if (rd_pend) begin
          we = 1'b1;
        end else begin
          addr = IDX_BITS'(idx - 1'b1);
        end
      end
      ST_PLACE: begin
        we = 1'b1;
        wdata = '{key: cur.key, prio: cur.priority_req, data: cur.payload};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      capacity <= 5'd16;
      count <= '0;
      hits <= '0;
      misses <= '0;
      rd_pend <= 1'b0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= 1'b0;
      if (cfg_we) capacity <= cfg_data;
      unique case (state)
        ST_IDLE: begin
          rsp <= '0;
          idx <= '0;
          rd_pend <= 1'b0;
          if (start) begin
            cur <= req;
            if (req.mode == MODE_INSERT && full) begin
              idx <= CNT_BITS'(count - 1'b1);
              count <= CNT_BITS'(count - 1'b1);
            end
          end
        end
        ST_EVICT: begin
          if (rd_pend) begin
            rsp.evicted <= 1'b1;
            rsp.evicted_key <= rdata.key;
            rsp.evicted_payload <= rdata.data;
            rsp.evicted_priority <= rdata.prio;
            idx <= '0;
            rd_pend <= 1'b0;
          end else rd_pend <= 1'b1;
        end
        ST_SCAN: begin
          if (state_next == ST_SCAN) begin
            rd_pend <= 1'b1;
            idx <= idx + 1'b1;
          end else begin
            rd_pend <= 1'b0;
            if (cur.mode == MODE_LOOKUP) begin
              if (rd_pend && rdata.key == cur.key) begin
                rsp.hit <= 1'b1;
                rsp.hit_payload <= rdata.data;
                rsp.hit_priority <= rdata.prio;
                hits <= hits + 1'b1;
              end else misses <= misses + 1'b1;
            end else if (state_next == ST_SHIFT) begin
              pos <= CNT_BITS'(idx - 1'b1);
              idx <= count;
            end else begin
              pos <= count;
              idx <= count;
            end
          end
        end
        ST_SHIFT: begin
          if (rd_pend) begin
            rd_pend <= 1'b0;
            idx <= idx - 1'b1;
          end else if (idx != pos) rd_pend <= 1'b1;
        end
        ST_PLACE: count <= count + 1'b1;
        ST_DONE: begin
          done <= 1'b1;
          rsp.hits_so_far <= hits;
          rsp.misses_so_far <= misses;
          rsp.entries_held <= count;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: src/poc_checker.sv
// Port level checks for the priority ordered cache, bound to the top level.
// Depends on poc_pkg.
`default_nettype none
module poc_checker
  import poc_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done,
  input wire rsp_t rsp
);
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("no busy after start");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without item");
  a_held_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (32'(rsp.entries_held) <= DEPTH)) else $error("entry count out of range");
  a_hit_evict: assert property (@(posedge clk) disable iff (rst)
    done |-> !(rsp.hit && rsp.evicted)) else $error("hit and eviction together");
endmodule
bind priority_ordered_cache_top poc_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .rsp(rsp)
);
`default_nettype wire
